// ----- sv/gyro_rate_integrator_core_defines.svh -----
// Assertion macros shared by the gyro rate integrator RTL.
`ifndef GYRO_RATE_INTEGRATOR_CORE_DEFINES_SVH
`define GYRO_RATE_INTEGRATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GRI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GRI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/gri_pkg.sv -----
// Shared types and constants for the gyro rate integrator.
package gri_pkg;

    typedef enum logic [1:0] {
        OP_INTEGRATE = 2'd0,
        OP_TRACK     = 2'd1,
        OP_CAL       = 2'd2,
        OP_ZERO      = 2'd3
    } t_op;

    localparam int SAMPLE_W = 12;
    localparam int TIME_W   = 32;
    localparam int ANGLE_W  = 32;
    localparam int SUM_W    = 16;
    localparam int CNT_W    = 4;

    // dt / 1000 split into quotient and remainder
    localparam int DQ_W = 23;
    localparam int DR_W = 10;
    localparam int X_W  = SAMPLE_W + DR_W;

    localparam logic [TIME_W-1:0] TIME_DIV    = 32'd1000;
    localparam logic [28:0]       DT_RECIP    = 29'd274877907;  // ceil(2^38 / 1000)
    localparam int                DT_SHIFT    = 38;
    localparam logic [22:0]       FRAC_RECIP  = 23'd4294968;    // ceil(2^32 / 1000)
    localparam int                FRAC_SHIFT  = 32;
    localparam logic [12:0]       TRACK_RECIP = 13'd6554;       // ceil(2^16 / 10)
    localparam int                TRACK_SHIFT = 16;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_pipe_en;

    typedef struct packed {
        t_op                 op;
        logic [SAMPLE_W-1:0] cx;
        logic [SAMPLE_W-1:0] cy;
        logic                done;
    } t_meta;

endpackage

// ----- sv/gri_time_div.sv -----
// Shared elapsed-time divider: splits dt into dt / 1000 and dt % 1000.
module gri_time_div import gri_pkg::*; (
    input  logic              i_clk,
    input  t_pipe_en          i_en,
    input  logic [TIME_W-1:0] i_dt,
    output logic [DQ_W-1:0]   o_dq,
    output logic [DR_W-1:0]   o_dr
);

    logic [TIME_W-1:0]    r_dt;
    logic [TIME_W-1:0]    r_dt2;
    logic [DQ_W-1:0]      r_dq;
    logic [DQ_W-1:0]      r_dq3;
    logic [DR_W-1:0]      r_dr;
    logic [TIME_W+28:0]   w_prod;
    logic [TIME_W-1:0]    w_rem;

    assign w_prod = {29'd0, r_dt} * {32'd0, DT_RECIP};
    assign w_rem  = r_dt2 - TIME_W'(r_dq) * TIME_DIV;

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_dt <= i_dt;
        end
        if (i_en.s2) begin
            r_dq  <= w_prod[DT_SHIFT+DQ_W-1:DT_SHIFT];
            r_dt2 <= r_dt;
        end
        if (i_en.s3) begin
            r_dq3 <= r_dq;
            r_dr  <= w_rem[DR_W-1:0];
        end
    end

    assign o_dq = r_dq3;
    assign o_dr = r_dr;

endmodule

// ----- sv/gri_lane.sv -----
// One axis lane: signed rate, rate * dt / 1000 magnitude and sign.
module gri_lane import gri_pkg::*; (
    input  logic                i_clk,
    input  t_pipe_en            i_en,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [SAMPLE_W-1:0] i_center,
    input  logic [DQ_W-1:0]     i_dq,
    input  logic [DR_W-1:0]     i_dr,
    output logic                o_neg,
    output logic [ANGLE_W-1:0]  o_quot
);

    logic [SAMPLE_W:0]     w_diff;
    logic [SAMPLE_W-1:0]   w_mag;
    logic [SAMPLE_W-1:0]   r_mag1, r_mag2, r_mag3;
    logic                  r_neg1, r_neg2, r_neg3, r_neg4, r_neg5;
    logic [X_W-1:0]        w_x;
    logic [SAMPLE_W+DQ_W-1:0] w_y;
    logic [X_W-1:0]        r_x;
    logic [ANGLE_W-1:0]    r_y;
    logic [X_W+22:0]       w_p;
    logic [12:0]           w_q2;
    logic [ANGLE_W-1:0]    r_q;

    assign w_diff = {1'b0, i_sample} - {1'b0, i_center};
    assign w_mag  = w_diff[SAMPLE_W] ? SAMPLE_W'(-w_diff) : w_diff[SAMPLE_W-1:0];

    // |rate| * dt / 1000 = |rate| * dq + (|rate| * dr) / 1000
    assign w_x  = {{DR_W{1'b0}}, r_mag3} * {{SAMPLE_W{1'b0}}, i_dr};
    assign w_y  = {{DQ_W{1'b0}}, r_mag3} * {{SAMPLE_W{1'b0}}, i_dq};
    assign w_p  = {23'd0, r_x} * {{X_W{1'b0}}, FRAC_RECIP};
    assign w_q2 = w_p[FRAC_SHIFT+12:FRAC_SHIFT];

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_mag1 <= w_mag;
            r_neg1 <= w_diff[SAMPLE_W];
        end
        if (i_en.s2) begin
            r_mag2 <= r_mag1;
            r_neg2 <= r_neg1;
        end
        if (i_en.s3) begin
            r_mag3 <= r_mag2;
            r_neg3 <= r_neg2;
        end
        if (i_en.s4) begin
            r_x    <= w_x;
            r_y    <= w_y[ANGLE_W-1:0];
            r_neg4 <= r_neg3;
        end
        if (i_en.s5) begin
            r_q    <= r_y + {19'd0, w_q2};
            r_neg5 <= r_neg4;
        end
    end

    assign o_neg  = r_neg5;
    assign o_quot = r_q;

endmodule

// ----- sv/gri_center.sv -----
// Zero-rate center state: tracking and calibration averaging.
`include "gyro_rate_integrator_core_defines.svh"
module gri_center import gri_pkg::*; #(
    parameter int CAL_SAMPLES = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  t_op                 i_op,
    input  logic [SAMPLE_W-1:0] i_sample_x,
    input  logic [SAMPLE_W-1:0] i_sample_y,
    output logic [SAMPLE_W-1:0] o_center_x,
    output logic [SAMPLE_W-1:0] o_center_y,
    output logic [SAMPLE_W-1:0] o_next_x,
    output logic [SAMPLE_W-1:0] o_next_y,
    output logic                o_done
);

    localparam logic [32:0] CAL_RECIP =
        33'(((64'd1 << 32) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

    logic [SAMPLE_W-1:0] r_center_x, r_center_y, n_center_x, n_center_y;
    logic [SUM_W-1:0]    r_sum_x, r_sum_y, n_sum_x, n_sum_y;
    logic [CNT_W-1:0]    r_cal_count, n_cal_count;
    logic                n_done;
    logic [CNT_W:0]      w_cnt_inc;
    logic [SUM_W-1:0]    w_sum_x, w_sum_y;
    logic [SUM_W+32:0]   w_div_x, w_div_y;
    logic                w_cal_hit;

    function automatic logic [SAMPLE_W-1:0] f_track(input logic [SAMPLE_W-1:0] c,
                                                    input logic [SAMPLE_W-1:0] s);
        logic [SAMPLE_W:0]   diff;
        logic [SAMPLE_W-1:0] mag;
        logic [24:0]         prod;
        logic [SAMPLE_W-1:0] step;
        diff = {1'b0, s} - {1'b0, c};
        mag  = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
        prod = {13'd0, mag} * {12'd0, TRACK_RECIP};
        step = {3'd0, prod[24:TRACK_SHIFT]};
        return diff[SAMPLE_W] ? (c - step) : (c + step);
    endfunction

    assign w_cnt_inc = {1'b0, r_cal_count} + 5'd1;
    assign w_cal_hit = (w_cnt_inc >= 5'(CAL_SAMPLES));
    assign w_sum_x   = r_sum_x + {4'd0, i_sample_x};
    assign w_sum_y   = r_sum_y + {4'd0, i_sample_y};
    assign w_div_x   = {33'd0, w_sum_x} * {16'd0, CAL_RECIP};
    assign w_div_y   = {33'd0, w_sum_y} * {16'd0, CAL_RECIP};

    always_comb begin
        n_center_x  = r_center_x;
        n_center_y  = r_center_y;
        n_sum_x     = r_sum_x;
        n_sum_y     = r_sum_y;
        n_cal_count = r_cal_count;
        n_done      = 1'b0;
        unique case (i_op)
            OP_TRACK: begin
                n_center_x = f_track(r_center_x, i_sample_x);
                n_center_y = f_track(r_center_y, i_sample_y);
            end
            OP_CAL: begin
                if (w_cal_hit) begin
                    n_center_x  = w_div_x[32+SAMPLE_W-1:32];
                    n_center_y  = w_div_y[32+SAMPLE_W-1:32];
                    n_sum_x     = '0;
                    n_sum_y     = '0;
                    n_cal_count = '0;
                    n_done      = 1'b1;
                end else begin
                    n_sum_x     = w_sum_x;
                    n_sum_y     = w_sum_y;
                    n_cal_count = w_cnt_inc[CNT_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x  <= '0;
            r_center_y  <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_cal_count <= '0;
        end else if (i_accept) begin
            r_center_x  <= n_center_x;
            r_center_y  <= n_center_y;
            r_sum_x     <= n_sum_x;
            r_sum_y     <= n_sum_y;
            r_cal_count <= n_cal_count;
        end
    end

    assign o_center_x = r_center_x;
    assign o_center_y = r_center_y;
    assign o_next_x   = n_center_x;
    assign o_next_y   = n_center_y;
    assign o_done     = n_done;

    `GRI_ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, 1'b1, ({1'b0, r_cal_count} < 5'(CAL_SAMPLES)), "calibration count reached its limit")
    `GRI_ASSERT_NEXT(a_done_clears, i_clk, i_rst_n, (i_accept && n_done), (r_cal_count == '0 && r_sum_x == '0 && r_sum_y == '0), "calibration state not cleared after average")
    `GRI_ASSERT_NEXT(a_cal_hold, i_clk, i_rst_n, (!i_accept || i_op != OP_CAL), ($stable(r_cal_count) && $stable(r_sum_x) && $stable(r_sum_y)), "calibration state moved without a calibration request")

endmodule

// ----- sv/gyro_rate_integrator_core.sv -----
// Top level of the two-axis gyro rate integrator with center tracking.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | request   | i_in_valid / o_in_ready    | i_op, i_sample_x, i_sample_y, i_time_us
//  out     | result    | o_out_valid / i_out_ready  | o_pitch_angle, o_roll_angle,
//          |           |                            | o_center_x, o_center_y,
//          |           |                            | o_calibration_done
//
// Throughput is one request per cycle while the output is not stalled; each request
// passes through the six-stage chain of reciprocal multipliers (dt / 1000 split,
// per-axis products, fraction divide, accumulate) from accept to result.
// Reset (i_rst_n low, synchronous) clears angles, centers, timestamp, calibration
// state and all stage valid bits; the block takes requests the cycle after release.
// A stalled output only holds the stages behind it that are full: empty stages keep
// filling, so o_in_ready drops only when every stage holds a request.
`include "gyro_rate_integrator_core_defines.svh"
module gyro_rate_integrator_core import gri_pkg::*; #(
    parameter int CAL_SAMPLES = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_op,
    input  logic [SAMPLE_W-1:0] i_sample_x,
    input  logic [SAMPLE_W-1:0] i_sample_y,
    input  logic [TIME_W-1:0]   i_time_us,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [ANGLE_W-1:0] o_pitch_angle,
    output logic signed [ANGLE_W-1:0] o_roll_angle,
    output logic [SAMPLE_W-1:0] o_center_x,
    output logic [SAMPLE_W-1:0] o_center_y,
    output logic                o_calibration_done
);

    t_op                 w_op;
    logic [6:1]          r_vld;
    logic [6:1]          w_go;
    t_pipe_en            w_en;
    logic                w_accept;
    logic [TIME_W-1:0]   r_last_time;
    logic [TIME_W-1:0]   w_dt;
    logic [SAMPLE_W-1:0] w_center_x, w_center_y, w_next_x, w_next_y;
    logic                w_done;
    logic [DQ_W-1:0]     w_dq;
    logic [DR_W-1:0]     w_dr;
    logic                w_neg_x, w_neg_y;
    logic [ANGLE_W-1:0]  w_quot_x, w_quot_y;
    t_meta               r_meta [1:6];
    logic [ANGLE_W-1:0]  r_pitch_acc, r_roll_acc;
    logic [ANGLE_W-1:0]  n_pitch_acc, n_roll_acc;

    assign w_op = t_op'(i_op);

    // Stage k may load when it is empty or its content moves on this cycle.
    assign w_go[6] = !r_vld[6] || i_out_ready;
    assign w_go[5] = !r_vld[5] || w_go[6];
    assign w_go[4] = !r_vld[4] || w_go[5];
    assign w_go[3] = !r_vld[3] || w_go[4];
    assign w_go[2] = !r_vld[2] || w_go[3];
    assign w_go[1] = !r_vld[1] || w_go[2];

    assign w_en       = '{s1: w_go[1], s2: w_go[2], s3: w_go[3], s4: w_go[4], s5: w_go[5]};
    // Hold ready low during reset so no request is taken and dropped.
    assign o_in_ready = w_go[1] && i_rst_n;
    assign w_accept   = i_in_valid && o_in_ready;

    // Elapsed time against the last integrate request, wrapping mod 2^32.
    assign w_dt = i_time_us - r_last_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_last_time <= '0;
        end else begin
            if (w_go[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= 6; k++) begin
                if (w_go[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (w_accept && w_op == OP_INTEGRATE) begin
                r_last_time <= i_time_us;
            end
        end
    end

    gri_center #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_center (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_op       (w_op),
        .i_sample_x (i_sample_x),
        .i_sample_y (i_sample_y),
        .o_center_x (w_center_x),
        .o_center_y (w_center_y),
        .o_next_x   (w_next_x),
        .o_next_y   (w_next_y),
        .o_done     (w_done)
    );

    gri_time_div u_time_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_dt  (w_dt),
        .o_dq  (w_dq),
        .o_dr  (w_dr)
    );

    // Pitch lane works on the x samples, roll lane on the y samples.
    gri_lane u_lane_x (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_sample (i_sample_x),
        .i_center (w_center_x),
        .i_dq     (w_dq),
        .i_dr     (w_dr),
        .o_neg    (w_neg_x),
        .o_quot   (w_quot_x)
    );

    gri_lane u_lane_y (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_sample (i_sample_y),
        .i_center (w_center_y),
        .i_dq     (w_dq),
        .i_dr     (w_dr),
        .o_neg    (w_neg_y),
        .o_quot   (w_quot_y)
    );

    // Carry op, post-update centers and done flag alongside the lanes.
    always_ff @(posedge i_clk) begin
        if (w_go[1]) begin
            r_meta[1] <= '{op: w_op, cx: w_next_x, cy: w_next_y, done: w_done};
        end
        for (int k = 2; k <= 6; k++) begin
            if (w_go[k]) begin
                r_meta[k] <= r_meta[k-1];
            end
        end
    end

    // Merge: apply the lane results or the zero request to the angle accumulators.
    always_comb begin
        n_pitch_acc = r_pitch_acc;
        n_roll_acc  = r_roll_acc;
        case (r_meta[5].op)
            OP_INTEGRATE: begin
                n_pitch_acc = w_neg_x ? (r_pitch_acc - w_quot_x) : (r_pitch_acc + w_quot_x);
                n_roll_acc  = w_neg_y ? (r_roll_acc - w_quot_y) : (r_roll_acc + w_quot_y);
            end
            OP_ZERO: begin
                n_pitch_acc = '0;
                n_roll_acc  = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch_acc <= '0;
            r_roll_acc  <= '0;
        end else if (w_go[6] && r_vld[5]) begin
            r_pitch_acc <= n_pitch_acc;
            r_roll_acc  <= n_roll_acc;
        end
    end

    // The accumulators double as the output angle registers.
    assign o_out_valid        = r_vld[6];
    assign o_pitch_angle      = r_pitch_acc;
    assign o_roll_angle       = r_roll_acc;
    assign o_center_x         = r_meta[6].cx;
    assign o_center_y         = r_meta[6].cy;
    assign o_calibration_done = r_meta[6].done;

    `GRI_ASSERT_IMPL(a_stall_only_full, i_clk, i_rst_n, !o_in_ready, (o_out_valid && !i_out_ready && r_vld[1]), "input stalled while the pipeline has room")
    `GRI_ASSERT_NEXT(a_zero_clears, i_clk, i_rst_n, (r_vld[5] && w_go[6] && r_meta[5].op == OP_ZERO), (r_pitch_acc == '0 && r_roll_acc == '0), "zero request left an angle set")
    `GRI_ASSERT_IMPL(a_done_from_cal, i_clk, i_rst_n, (o_out_valid && o_calibration_done), (r_meta[6].op == OP_CAL), "calibration done on a non-calibration result")

endmodule
